[rtl/ngfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA field extractor package
// Shared constants, character codes and payload types of the extractor.
// ----------------------------------------------------------------------------
package ngfe_pkg;

    localparam int MAX_SENTENCE_DEF = 83;
    localparam int TIME_CHARS_DEF   = 6;
    localparam int LAT_CHARS_DEF    = 9;
    localparam int LON_CHARS_DEF    = 10;
    localparam int SAT_CHARS        = 2;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_TALKER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TALKER_SECOND = 8'd1;

    localparam logic [7:0] TALKER_FIRST_RST  = 8'd71;
    localparam logic [7:0] TALKER_SECOND_RST = 8'd80;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic [6:0] HEADER_LEN = 7'd6;
    localparam logic [6:0] HDR_DOLLAR = 7'd0;
    localparam logic [6:0] HDR_FIRST  = 7'd1;
    localparam logic [6:0] HDR_SECOND = 7'd2;
    localparam logic [6:0] HDR_LAST   = 7'd5;

    localparam logic [3:0] FLD_TIME = 4'd1;
    localparam logic [3:0] FLD_LAT  = 4'd2;
    localparam logic [3:0] FLD_NS   = 4'd3;
    localparam logic [3:0] FLD_LON  = 4'd4;
    localparam logic [3:0] FLD_EW   = 4'd5;
    localparam logic [3:0] FLD_FIX  = 4'd6;
    localparam logic [3:0] FLD_SAT  = 4'd7;
    localparam logic [3:0] FLD_ALT  = 4'd9;
    localparam logic [3:0] FLD_MAX  = 4'd15;
    localparam logic [6:0] POS_MAX  = 7'd127;

    localparam logic [1:0] TAG_TIME = 2'd0;
    localparam logic [1:0] TAG_LAT  = 2'd1;
    localparam logic [1:0] TAG_LON  = 2'd2;
    localparam logic [1:0] TAG_SAT  = 2'd3;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [15:0] ALT_NEG_LIMIT = 16'd32768;
    localparam logic [15:0] ALT_POS_LIMIT = 16'd32767;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } ngfe_talker_t;

    typedef struct packed {
        logic              result_kind;
        logic [1:0]        field_tag;
        logic [3:0]        char_index;
        logic [7:0]        char_value;
        logic              is_gga;
        logic              fix_ok;
        logic              lat_south;
        logic              lon_west;
        logic signed [15:0] altitude_m;
        logic              altitude_valid;
    } ngfe_result_t;

endpackage

[rtl/ngfe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA field extractor channels
// Valid/ready channels for characters, results and configuration writes.
// ----------------------------------------------------------------------------
interface ngfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface ngfe_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [1:0]         field_tag;
    logic [3:0]         char_index;
    logic [7:0]         char_value;
    logic               is_gga;
    logic               fix_ok;
    logic               lat_south;
    logic               lon_west;
    logic signed [15:0] altitude_m;
    logic               altitude_valid;

    modport source (
        output valid, output result_kind, output field_tag, output char_index,
        output char_value, output is_gga, output fix_ok, output lat_south,
        output lon_west, output altitude_m, output altitude_valid, input ready
    );
    modport sink (
        input valid, input result_kind, input field_tag, input char_index,
        input char_value, input is_gga, input fix_ok, input lat_south,
        input lon_west, input altitude_m, input altitude_valid, output ready
    );
endinterface

interface ngfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ngfe_pkg::CFG_INDEX_W-1:0] index;
    logic [7:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/nmea_gga_field_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA field extractor
// Matches the GGA header, emits leading characters of selected fields and
// gives a summary of hemispheres, fix and altitude at each newline.
// Each accepted character is held in the input register and its result in the
// result register. One character is accepted every cycle while the output is not
// stalled, set by the single pass from input through parser to result register.
// Reset clears all sentence state and loads the talker registers with G and P.
// ----------------------------------------------------------------------------
module nmea_gga_field_extractor #(
    parameter int MAX_SENTENCE = ngfe_pkg::MAX_SENTENCE_DEF,
    parameter int TIME_CHARS   = ngfe_pkg::TIME_CHARS_DEF,
    parameter int LAT_CHARS    = ngfe_pkg::LAT_CHARS_DEF,
    parameter int LON_CHARS    = ngfe_pkg::LON_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ngfe_in_if.sink     rx,
    ngfe_out_if.source  tx,
    ngfe_cfg_if.sink    cfg
);

    ngfe_pkg::ngfe_talker_t talker;
    ngfe_pkg::ngfe_result_t res;
    ngfe_pkg::ngfe_result_t out_data_reg;
    logic                   res_valid;
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             char_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   advance;
    logic                   step;

    ngfe_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .talker (talker)
    );

    ngfe_parse #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .TIME_CHARS   (TIME_CHARS),
        .LAT_CHARS    (LAT_CHARS),
        .LON_CHARS    (LON_CHARS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_in   (char_reg),
        .talker    (talker),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance  = !out_valid_reg || tx.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    assign in_valid_next  = rx.ready ? rx.valid : in_valid_reg;
    assign out_valid_next = advance ? (in_valid_reg && res_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            char_reg <= rx.char_in;
        end
        if (step && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.result_kind    = out_data_reg.result_kind;
    assign tx.field_tag      = out_data_reg.field_tag;
    assign tx.char_index     = out_data_reg.char_index;
    assign tx.char_value     = out_data_reg.char_value;
    assign tx.is_gga         = out_data_reg.is_gga;
    assign tx.fix_ok         = out_data_reg.fix_ok;
    assign tx.lat_south      = out_data_reg.lat_south;
    assign tx.lon_west       = out_data_reg.lon_west;
    assign tx.altitude_m     = out_data_reg.altitude_m;
    assign tx.altitude_valid = out_data_reg.altitude_valid;

    a_char_no_summary: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && (tx.result_kind == ngfe_pkg::KIND_CHAR)
        |-> !tx.is_gga && !tx.altitude_valid && (tx.altitude_m == 16'sd0))
        else $error("Character item carries summary fields");

    a_alt_needs_gga: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.altitude_valid
        |-> tx.is_gga && (tx.result_kind == ngfe_pkg::KIND_SUMMARY))
        else $error("Altitude reported without a matching header");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(char_reg))
        else $error("Buffered character lost during an output stall");

endmodule

[rtl/ngfe_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA talker registers
// Holds the two expected talker characters; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module ngfe_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    ngfe_cfg_if.sink              cfg,
    output ngfe_pkg::ngfe_talker_t talker
);

    logic [7:0] first_reg;
    logic [7:0] second_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= ngfe_pkg::TALKER_FIRST_RST;
            second_reg <= ngfe_pkg::TALKER_SECOND_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == ngfe_pkg::REG_TALKER_FIRST)
            begin
                first_reg <= cfg.data;
            end
            if (cfg.index == ngfe_pkg::REG_TALKER_SECOND)
            begin
                second_reg <= cfg.data;
            end
        end
    end

    assign talker.first  = first_reg;
    assign talker.second = second_reg;

endmodule

[rtl/ngfe_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA sentence parser
// Per-sentence state and the single-pass logic that handles one character.
// ----------------------------------------------------------------------------
module ngfe_parse #(
    parameter int MAX_SENTENCE = ngfe_pkg::MAX_SENTENCE_DEF,
    parameter int TIME_CHARS   = ngfe_pkg::TIME_CHARS_DEF,
    parameter int LAT_CHARS    = ngfe_pkg::LAT_CHARS_DEF,
    parameter int LON_CHARS    = ngfe_pkg::LON_CHARS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_in,
    input  ngfe_pkg::ngfe_talker_t talker,
    output logic                   res_valid,
    output ngfe_pkg::ngfe_result_t res
);

    localparam logic [6:0] MAX_POS  = 7'(MAX_SENTENCE);
    localparam logic [3:0] TIME_LIM = 4'(TIME_CHARS);
    localparam logic [3:0] LAT_LIM  = 4'(LAT_CHARS);
    localparam logic [3:0] LON_LIM  = 4'(LON_CHARS);
    localparam logic [3:0] SAT_LIM  = 4'(ngfe_pkg::SAT_CHARS);

    logic [6:0]  sentence_pos_reg, sentence_pos_next;
    logic [3:0]  field_number_reg, field_number_next;
    logic [6:0]  pos_in_field_reg, pos_in_field_next;
    logic        header_ok_reg, header_ok_next;
    logic [7:0]  prev_char_reg, prev_char_next;
    logic        stopped_reg, stopped_next;
    logic        fix_seen_ok_reg, fix_seen_ok_next;
    logic        south_reg, south_next;
    logic        west_reg, west_next;
    logic [15:0] alt_accum_reg, alt_accum_next;
    logic        alt_neg_reg, alt_neg_next;
    logic        alt_done_reg, alt_done_next;
    logic        alt_valid_reg, alt_valid_next;

    logic [7:0]  want;
    logic [19:0] alt_prod;
    logic        is_digit;
    logic [3:0]  lim;
    logic [1:0]  tag;
    logic        gga;

    always_comb
    begin
        unique case (sentence_pos_reg)
            ngfe_pkg::HDR_DOLLAR: want = ngfe_pkg::CH_DOLLAR;
            ngfe_pkg::HDR_FIRST:  want = talker.first;
            ngfe_pkg::HDR_SECOND: want = talker.second;
            ngfe_pkg::HDR_LAST:   want = ngfe_pkg::CH_A;
            default:              want = ngfe_pkg::CH_G;
        endcase
    end

    always_comb
    begin
        unique case (field_number_reg)
            ngfe_pkg::FLD_TIME: begin tag = ngfe_pkg::TAG_TIME; lim = TIME_LIM; end
            ngfe_pkg::FLD_LAT:  begin tag = ngfe_pkg::TAG_LAT;  lim = LAT_LIM;  end
            ngfe_pkg::FLD_LON:  begin tag = ngfe_pkg::TAG_LON;  lim = LON_LIM;  end
            ngfe_pkg::FLD_SAT:  begin tag = ngfe_pkg::TAG_SAT;  lim = SAT_LIM;  end
            default:            begin tag = ngfe_pkg::TAG_TIME; lim = 4'd0;     end
        endcase
    end

    assign is_digit = (char_in >= ngfe_pkg::CH_ZERO) && (char_in <= ngfe_pkg::CH_NINE);
    assign alt_prod = {1'b0, alt_accum_reg, 3'b000} + {3'b000, alt_accum_reg, 1'b0}
                    + {16'd0, 4'(char_in - ngfe_pkg::CH_ZERO)};
    assign gga      = header_ok_reg && (sentence_pos_reg >= ngfe_pkg::HEADER_LEN);

    always_comb
    begin
        sentence_pos_next = sentence_pos_reg;
        field_number_next = field_number_reg;
        pos_in_field_next = pos_in_field_reg;
        header_ok_next    = header_ok_reg;
        prev_char_next    = prev_char_reg;
        stopped_next      = stopped_reg;
        fix_seen_ok_next  = fix_seen_ok_reg;
        south_next        = south_reg;
        west_next         = west_reg;
        alt_accum_next    = alt_accum_reg;
        alt_neg_next      = alt_neg_reg;
        alt_done_next     = alt_done_reg;
        alt_valid_next    = alt_valid_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (char_in == ngfe_pkg::CH_NL)
        begin
            res_valid       = 1'b1;
            res.result_kind = ngfe_pkg::KIND_SUMMARY;
            if (gga)
            begin
                res.is_gga    = 1'b1;
                res.fix_ok    = fix_seen_ok_reg;
                res.lat_south = south_reg;
                res.lon_west  = west_reg;
                if (alt_valid_reg)
                begin
                    res.altitude_valid = 1'b1;
                    if (alt_neg_reg)
                    begin
                        res.altitude_m = -$signed(alt_accum_reg);
                    end
                    else if (alt_accum_reg > ngfe_pkg::ALT_POS_LIMIT)
                    begin
                        res.altitude_m = $signed(ngfe_pkg::ALT_POS_LIMIT);
                    end
                    else
                    begin
                        res.altitude_m = $signed(alt_accum_reg);
                    end
                end
            end
            sentence_pos_next = '0;
            field_number_next = '0;
            pos_in_field_next = '0;
            header_ok_next    = 1'b1;
            prev_char_next    = '0;
            stopped_next      = 1'b0;
            fix_seen_ok_next  = 1'b0;
            south_next        = 1'b0;
            west_next         = 1'b0;
            alt_accum_next    = '0;
            alt_neg_next      = 1'b0;
            alt_done_next     = 1'b0;
            alt_valid_next    = 1'b0;
        end
        else if (sentence_pos_reg < MAX_POS)
        begin
            sentence_pos_next = sentence_pos_reg + 7'd1;
            if (!header_ok_reg || stopped_reg)
            begin
                // The rest of the sentence is skipped.
            end
            else if ((sentence_pos_reg < ngfe_pkg::HEADER_LEN) && (char_in != want))
            begin
                header_ok_next = 1'b0;
            end
            else if (char_in == ngfe_pkg::CH_COMMA)
            begin
                unique case (field_number_reg)
                    ngfe_pkg::FLD_NS: south_next = (prev_char_reg == ngfe_pkg::CH_S);
                    ngfe_pkg::FLD_EW: west_next  = (prev_char_reg == ngfe_pkg::CH_W);
                    ngfe_pkg::FLD_FIX:
                    begin
                        fix_seen_ok_next = (prev_char_reg != ngfe_pkg::CH_ZERO);
                        stopped_next     = (prev_char_reg == ngfe_pkg::CH_ZERO);
                    end
                    ngfe_pkg::FLD_ALT: alt_valid_next = 1'b1;
                    default: ;
                endcase
                if (field_number_reg != ngfe_pkg::FLD_MAX)
                begin
                    field_number_next = field_number_reg + 4'd1;
                end
                pos_in_field_next = '0;
                prev_char_next    = char_in;
            end
            else
            begin
                if ((field_number_reg == ngfe_pkg::FLD_ALT) && !alt_done_reg)
                begin
                    priority if ((pos_in_field_reg == '0) && (char_in == ngfe_pkg::CH_MINUS))
                    begin
                        alt_neg_next = 1'b1;
                    end
                    else if ((pos_in_field_reg == '0) && (char_in == ngfe_pkg::CH_PLUS))
                    begin
                        alt_neg_next = alt_neg_reg;
                    end
                    else if (is_digit)
                    begin
                        alt_accum_next = (alt_prod > {4'd0, ngfe_pkg::ALT_NEG_LIMIT})
                                       ? ngfe_pkg::ALT_NEG_LIMIT : alt_prod[15:0];
                    end
                    else
                    begin
                        alt_done_next = 1'b1;
                    end
                end
                if (pos_in_field_reg < {3'd0, lim})
                begin
                    res_valid       = 1'b1;
                    res.result_kind = ngfe_pkg::KIND_CHAR;
                    res.field_tag   = tag;
                    res.char_index  = pos_in_field_reg[3:0];
                    res.char_value  = char_in;
                end
                if (pos_in_field_reg != ngfe_pkg::POS_MAX)
                begin
                    pos_in_field_next = pos_in_field_reg + 7'd1;
                end
                prev_char_next = char_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentence_pos_reg <= '0;
            field_number_reg <= '0;
            pos_in_field_reg <= '0;
            header_ok_reg    <= 1'b1;
            prev_char_reg    <= '0;
            stopped_reg      <= 1'b0;
            fix_seen_ok_reg  <= 1'b0;
            south_reg        <= 1'b0;
            west_reg         <= 1'b0;
            alt_accum_reg    <= '0;
            alt_neg_reg      <= 1'b0;
            alt_done_reg     <= 1'b0;
            alt_valid_reg    <= 1'b0;
        end
        else if (step)
        begin
            sentence_pos_reg <= sentence_pos_next;
            field_number_reg <= field_number_next;
            pos_in_field_reg <= pos_in_field_next;
            header_ok_reg    <= header_ok_next;
            prev_char_reg    <= prev_char_next;
            stopped_reg      <= stopped_next;
            fix_seen_ok_reg  <= fix_seen_ok_next;
            south_reg        <= south_next;
            west_reg         <= west_next;
            alt_accum_reg    <= alt_accum_next;
            alt_neg_reg      <= alt_neg_next;
            alt_done_reg     <= alt_done_next;
            alt_valid_reg    <= alt_valid_next;
        end
    end

endmodule
